// ===== hdl/mrc_pkg.sv =====
// mrc_pkg: shared types, command codes and arithmetic helpers for the mouse report coalescer
// no dependencies; used by mrc_ctrl, mrc_datapath and mouse_report_coalescer
package mrc_pkg;

    localparam int ACC_LIMIT = 1008;
    localparam int ACC_W     = 11;
    localparam int SUM_W     = 18;

    typedef enum logic [2:0] {
        CMD_MOVE    = 3'd0,
        CMD_WHEEL   = 3'd1,
        CMD_ONE_BTN = 3'd2,
        CMD_ALL_BTN = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_RESET   = 3'd5,
        CMD_FLUSH   = 3'd6,
        CMD_TICK    = 3'd7
    } t_command;

    typedef enum logic [1:0] {
        REG_FLUSH_TICKS = 2'd0,
        REG_BUTTON_MASK = 2'd1,
        REG_MAX_DELTA   = 2'd2,
        REG_MIN_DELTA   = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_BTN   = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;         // input word accepted this cycle
        logic emit_motion;  // load one clamped motion report
        logic emit_button;  // load the button report
        logic last;         // final report of the current item
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic flush_go;     // accepted word asks for a flush
        logic btn_go;       // accepted word changes the buttons
        logic pend_nz;      // some accumulator is nonzero
        logic rem_zero;     // accumulators are zero after this report
        logic btn_pend;     // button report follows the flush
        logic out_free;     // output register can take a word
    } t_status;

    // add a 16-bit delta, saturate at the accumulator bound
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [15:0]      d
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] lim;
        begin
            lim = SUM_W'(ACC_LIMIT);
            s   = $signed({{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc})
                + $signed({{(SUM_W-16){d[15]}}, d});
            if (s > lim) begin
                sat_add = ACC_W'(ACC_LIMIT);
            end else if (s < -lim) begin
                sat_add = -ACC_W'(ACC_LIMIT);
            end else begin
                sat_add = s[ACC_W-1:0];
            end
        end
    endfunction

    // clamp an accumulator to the report delta range
    function automatic logic signed [7:0] clamp_delta(
        input logic signed [ACC_W-1:0] v,
        input logic signed [7:0]       hi,
        input logic signed [7:0]       lo
    );
        logic signed [ACC_W-1:0] hi_x;
        logic signed [ACC_W-1:0] lo_x;
        begin
            hi_x = $signed({{(ACC_W-8){hi[7]}}, hi});
            lo_x = $signed({{(ACC_W-8){lo[7]}}, lo});
            if (v > hi_x) begin
                clamp_delta = hi;
            end else if (v < lo_x) begin
                clamp_delta = lo;
            end else begin
                clamp_delta = v[7:0];
            end
        end
    endfunction

endpackage

// ===== hdl/mouse_report_coalescer.sv =====
// mouse_report_coalescer: top level, gathers mouse motion into saturating accumulators
// and sends clamped relative reports; depends on mrc_pkg, mrc_ctrl, mrc_datapath
// report words are registered: a taken command moves the sequencer state, then each report loads the output register
// input: a command with reports holds the input stall high until its last report is loaded
// (one report per cycle while the output is not stalled, up to 64); others do not hold the input
// reset: synchronous active low, clears accumulators, timer, buttons and the output valid flag
module mouse_report_coalescer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic signed [15:0] i_wheel_amount,
    input  logic [7:0]         i_button_bits,
    input  logic               i_pressed,
    // report word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_report_valid,
    output logic [7:0]         o_report_buttons,
    output logic signed [7:0]  o_report_x,
    output logic signed [7:0]  o_report_y,
    output logic signed [7:0]  o_report_wheel,
    output logic               o_buttons_changed,
    output logic               o_last
);

    // command and status between sequencer and datapath
    mrc_pkg::t_cmd    cmd;
    mrc_pkg::t_status status;

    // sequencer: takes a word while idle, then walks flush reports
    // and the trailing button report, one per free output slot
    mrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: decode, accumulators, timer, clamp and output register
    mrc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_command         (i_command),
        .i_move_x          (i_move_x),
        .i_move_y          (i_move_y),
        .i_wheel_amount    (i_wheel_amount),
        .i_button_bits     (i_button_bits),
        .i_pressed         (i_pressed),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_report_valid    (o_report_valid),
        .o_report_buttons  (o_report_buttons),
        .o_report_x        (o_report_x),
        .o_report_y        (o_report_y),
        .o_report_wheel    (o_report_wheel),
        .o_buttons_changed (o_buttons_changed),
        .o_last            (o_last)
    );

endmodule

// ===== hdl/mrc_ctrl.sv =====
// mrc_ctrl: sequencer for accept, flush reports and the button report
// depends on mrc_pkg (state, command and status types)
module mrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mrc_pkg::t_status  i_status,
    output logic              o_in_stall,
    output mrc_pkg::t_cmd     o_cmd
);

    mrc_pkg::t_state r_state;
    mrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != mrc_pkg::ST_IDLE);

    always_comb begin
        n_state           = r_state;
        o_cmd.take        = 1'b0;
        o_cmd.emit_motion = 1'b0;
        o_cmd.emit_button = 1'b0;
        o_cmd.last        = 1'b0;
        case (r_state)
            mrc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_status.flush_go && i_status.pend_nz) begin
                        n_state = mrc_pkg::ST_FLUSH;
                    end else if (i_status.btn_go) begin
                        n_state = mrc_pkg::ST_BTN;
                    end
                end
            end
            mrc_pkg::ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.emit_motion = 1'b1;
                    o_cmd.last        = i_status.rem_zero && !i_status.btn_pend;
                    if (i_status.rem_zero) begin
                        n_state = i_status.btn_pend ? mrc_pkg::ST_BTN : mrc_pkg::ST_IDLE;
                    end
                end
            end
            mrc_pkg::ST_BTN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_button = 1'b1;
                    o_cmd.last        = 1'b1;
                    n_state           = mrc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mrc_datapath.sv =====
// mrc_datapath: config registers, accumulators, flush timer, buttons, output register
// depends on mrc_pkg (types, command codes, saturate and clamp helpers)
module mrc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic [2:0]          i_command,
    input  logic signed [15:0]  i_move_x,
    input  logic signed [15:0]  i_move_y,
    input  logic signed [15:0]  i_wheel_amount,
    input  logic [7:0]          i_button_bits,
    input  logic                i_pressed,
    input  mrc_pkg::t_cmd       i_cmd,
    output mrc_pkg::t_status    o_status,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_report_valid,
    output logic [7:0]          o_report_buttons,
    output logic signed [7:0]   o_report_x,
    output logic signed [7:0]   o_report_y,
    output logic signed [7:0]   o_report_wheel,
    output logic                o_buttons_changed,
    output logic                o_last
);

    localparam int AW = mrc_pkg::ACC_W;

    // configuration
    logic [15:0]        r_flush_ticks;
    logic [7:0]         r_button_mask;
    logic [6:0]         r_max_delta;
    logic signed [7:0]  r_min_delta;

    // state
    logic signed [AW-1:0] r_acc_x, r_acc_y, r_acc_w;
    logic signed [AW-1:0] n_acc_x, n_acc_y, n_acc_w;
    logic [7:0]           r_btn, n_btn;
    logic [7:0]           r_btn_next, n_btn_next;
    logic                 r_btn_pend, n_btn_pend;
    logic                 r_tmr_run, n_tmr_run;
    logic [15:0]          r_tmr_left, n_tmr_left;

    // output register
    logic                 r_out_valid;
    logic [7:0]           r_rep_btn;
    logic signed [7:0]    r_rep_x, r_rep_y, r_rep_w;
    logic                 r_rep_chg, r_rep_last;

    logic signed [7:0]    hi, lo;
    logic signed [7:0]    dx, dy, dw;
    logic signed [AW-1:0] rem_x, rem_y, rem_w;
    logic [7:0]           one_next, new_btn;
    logic                 flush_go, btn_go, start_tmr, out_free;
    logic [15:0]          load_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_ticks <= 16'd4;
            r_button_mask <= 8'd31;
            r_max_delta   <= 7'd127;
            r_min_delta   <= -8'sd127;
        end else if (i_cfg_we) begin
            case (mrc_pkg::t_reg_index'(i_cfg_index))
                mrc_pkg::REG_FLUSH_TICKS: r_flush_ticks <= i_cfg_data;
                mrc_pkg::REG_BUTTON_MASK: r_button_mask <= i_cfg_data[7:0];
                mrc_pkg::REG_MAX_DELTA:   r_max_delta   <= i_cfg_data[6:0];
                mrc_pkg::REG_MIN_DELTA:   r_min_delta   <= $signed(i_cfg_data[7:0]);
                default: ;
            endcase
        end
    end

    assign hi = (r_max_delta < 7'd16) ? 8'sd16 : $signed({1'b0, r_max_delta});
    assign lo = (r_min_delta > -8'sd16) ? -8'sd16 : r_min_delta;

    assign dx = mrc_pkg::clamp_delta(r_acc_x, hi, lo);
    assign dy = mrc_pkg::clamp_delta(r_acc_y, hi, lo);
    assign dw = mrc_pkg::clamp_delta(r_acc_w, hi, lo);

    assign rem_x = r_acc_x - $signed({{(AW-8){dx[7]}}, dx});
    assign rem_y = r_acc_y - $signed({{(AW-8){dy[7]}}, dy});
    assign rem_w = r_acc_w - $signed({{(AW-8){dw[7]}}, dw});

    assign one_next   = i_pressed ? (r_btn | i_button_bits) : (r_btn & ~i_button_bits);
    assign load_ticks = (r_flush_ticks == 16'd0) ? 16'd1 : r_flush_ticks;
    assign out_free   = !r_out_valid || !i_out_stall;

    // decode of the word at the input
    always_comb begin
        flush_go  = 1'b0;
        btn_go    = 1'b0;
        start_tmr = 1'b0;
        new_btn   = r_btn;
        case (mrc_pkg::t_command'(i_command))
            mrc_pkg::CMD_MOVE: begin
                start_tmr = (i_move_x != 16'sd0) || (i_move_y != 16'sd0);
            end
            mrc_pkg::CMD_WHEEL: begin
                start_tmr = (i_wheel_amount != 16'sd0);
            end
            mrc_pkg::CMD_ONE_BTN: begin
                new_btn = one_next & r_button_mask;
                btn_go  = (i_button_bits != 8'd0)
                       && ((i_button_bits & ~r_button_mask) == 8'd0)
                       && (new_btn != r_btn);
                flush_go = btn_go;
            end
            mrc_pkg::CMD_ALL_BTN: begin
                new_btn  = i_button_bits & r_button_mask;
                btn_go   = (new_btn != r_btn);
                flush_go = btn_go;
            end
            mrc_pkg::CMD_RELEASE: begin
                new_btn  = 8'd0;
                btn_go   = (r_btn != 8'd0);
                flush_go = 1'b1;
            end
            mrc_pkg::CMD_FLUSH: begin
                flush_go = 1'b1;
            end
            mrc_pkg::CMD_TICK: begin
                flush_go = r_tmr_run && (r_tmr_left <= 16'd1);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_acc_w    = r_acc_w;
        n_btn      = r_btn;
        n_btn_next = r_btn_next;
        n_btn_pend = r_btn_pend;
        n_tmr_run  = r_tmr_run;
        n_tmr_left = r_tmr_left;
        if (i_cmd.take) begin
            n_btn_next = new_btn;
            n_btn_pend = btn_go;
            if (mrc_pkg::t_command'(i_command) == mrc_pkg::CMD_RESET) begin
                n_acc_x    = '0;
                n_acc_y    = '0;
                n_acc_w    = '0;
                n_btn      = '0;
                n_tmr_run  = 1'b0;
                n_tmr_left = '0;
            end else if (flush_go) begin
                n_tmr_run  = 1'b0;
                n_tmr_left = '0;
            end else if (start_tmr) begin
                if (mrc_pkg::t_command'(i_command) == mrc_pkg::CMD_MOVE) begin
                    n_acc_x = mrc_pkg::sat_add(r_acc_x, i_move_x);
                    n_acc_y = mrc_pkg::sat_add(r_acc_y, i_move_y);
                end else begin
                    n_acc_w = mrc_pkg::sat_add(r_acc_w, i_wheel_amount);
                end
                if (!r_tmr_run) begin
                    n_tmr_run  = 1'b1;
                    n_tmr_left = load_ticks;
                end
            end else if (mrc_pkg::t_command'(i_command) == mrc_pkg::CMD_TICK
                         && r_tmr_run) begin
                n_tmr_left = r_tmr_left - 16'd1;
            end
        end
        if (i_cmd.emit_motion) begin
            n_acc_x = rem_x;
            n_acc_y = rem_y;
            n_acc_w = rem_w;
        end
        if (i_cmd.emit_button) begin
            n_btn = r_btn_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_w     <= '0;
            r_btn       <= '0;
            r_btn_pend  <= 1'b0;
            r_tmr_run   <= 1'b0;
            r_tmr_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_x    <= n_acc_x;
            r_acc_y    <= n_acc_y;
            r_acc_w    <= n_acc_w;
            r_btn      <= n_btn;
            r_btn_pend <= n_btn_pend;
            r_tmr_run  <= n_tmr_run;
            r_tmr_left <= n_tmr_left;
            if (i_cmd.emit_motion || i_cmd.emit_button) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_btn_next <= n_btn_next;
        if (i_cmd.emit_motion) begin
            r_rep_btn  <= r_btn;
            r_rep_x    <= dx;
            r_rep_y    <= dy;
            r_rep_w    <= dw;
            r_rep_chg  <= 1'b0;
            r_rep_last <= i_cmd.last;
        end else if (i_cmd.emit_button) begin
            r_rep_btn  <= r_btn_next;
            r_rep_x    <= '0;
            r_rep_y    <= '0;
            r_rep_w    <= '0;
            r_rep_chg  <= 1'b1;
            r_rep_last <= i_cmd.last;
        end
    end

    assign o_status.flush_go = flush_go;
    assign o_status.btn_go   = btn_go;
    assign o_status.pend_nz  = (r_acc_x != '0) || (r_acc_y != '0) || (r_acc_w != '0);
    assign o_status.rem_zero = (rem_x == '0) && (rem_y == '0) && (rem_w == '0);
    assign o_status.btn_pend = r_btn_pend;
    assign o_status.out_free = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_report_valid    = r_out_valid;
    assign o_report_buttons  = r_rep_btn;
    assign o_report_x        = r_rep_x;
    assign o_report_y        = r_rep_y;
    assign o_report_wheel    = r_rep_w;
    assign o_buttons_changed = r_rep_chg;
    assign o_last            = r_rep_last;

endmodule

// ===== dv/mouse_report_coalescer_tb.sv =====
// mouse_report_coalescer_tb: self-checking testbench for the mouse report coalescer
// drives command words and register writes, predicts every report in place and checks them
// depends on mrc_pkg and mouse_report_coalescer
module mouse_report_coalescer_tb;
    import mrc_pkg::*;

    localparam int LATENCY_PAD      = 8;    // cycles after the last report before a register write
    localparam int LONG_HOLD        = 300;  // output hold-off that fills the block up
    localparam int MAX_REPORTS      = 64;   // one word never causes more reports than this
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct {
        logic [7:0]        buttons;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] dw;
        logic              changed;
        logic              last;
    } t_report;

    // clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = REG_FLUSH_TICKS;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_command = CMD_TICK;
    logic signed [15:0] i_move_x = '0;
    logic signed [15:0] i_move_y = '0;
    logic signed [15:0] i_wheel_amount = '0;
    logic [7:0]         i_button_bits = '0;
    logic               i_pressed = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_report_valid;
    logic [7:0]         o_report_buttons;
    logic signed [7:0]  o_report_x;
    logic signed [7:0]  o_report_y;
    logic signed [7:0]  o_report_wheel;
    logic               o_buttons_changed;
    logic               o_last;

    // register copies and coalescer state of the predictor
    logic [15:0]        cfg_flush_ticks;
    logic [7:0]         cfg_button_mask;
    logic [6:0]         cfg_max_delta;
    logic signed [7:0]  cfg_min_delta;
    int                 acc_x;
    int                 acc_y;
    int                 acc_w;
    logic [7:0]         buttons_now;
    bit                 timer_on;
    int                 timer_left;

    t_report            item_reports[$];      // reports of the word being predicted
    t_report            expected_reports[$];  // reports still owed by the block

    // run bookkeeping
    bit                 calm = 1'b0;          // no idling on either side while set
    int                 hold_requests = 0;
    int                 holds_served = 0;
    int                 stall_left = 0;
    int                 mismatches = 0;
    int                 reports_checked = 0;
    int                 settings_used = 1;
    int                 words_per_cmd[8];

    mouse_report_coalescer dut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic int acc_sat(int a, int d);
        int r;
        r = a + d;
        if (r > ACC_LIMIT) r = ACC_LIMIT;
        if (r < -ACC_LIMIT) r = -ACC_LIMIT;
        return r;
    endfunction

    // bounds below the legal range fall back to plus or minus 16
    function automatic int report_delta(int v);
        int hi;
        int lo;
        hi = int'(cfg_max_delta);
        lo = int'(cfg_min_delta);
        if (hi < 16) hi = 16;
        if (lo > -16) lo = -16;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    task automatic reset_predictor();
        cfg_flush_ticks = 16'd4;
        cfg_button_mask = 8'd31;
        cfg_max_delta   = 7'd127;
        cfg_min_delta   = -8'sd127;
        acc_x           = 0;
        acc_y           = 0;
        acc_w           = 0;
        buttons_now     = '0;
        timer_on        = 1'b0;
        timer_left      = 0;
    endtask

    task automatic push_report(logic [7:0] btn, int dx, int dy, int dw, logic chg);
        t_report r;
        r.buttons = btn;
        r.dx      = 8'(dx);
        r.dy      = 8'(dy);
        r.dw      = 8'(dw);
        r.changed = chg;
        r.last    = 1'b0;
        item_reports.push_back(r);
    endtask

    // first motion arms the one-shot timer, later motion leaves it alone
    task automatic arm_timer();
        if (!timer_on) begin
            timer_on   = 1'b1;
            timer_left = (cfg_flush_ticks == 0) ? 1 : int'(cfg_flush_ticks);
        end
    endtask

    task automatic flush_motion();
        int dx;
        int dy;
        int dw;
        timer_on   = 1'b0;
        timer_left = 0;
        while ((acc_x != 0 || acc_y != 0 || acc_w != 0) && item_reports.size() < MAX_REPORTS) begin
            dx    = report_delta(acc_x);
            dy    = report_delta(acc_y);
            dw    = report_delta(acc_w);
            acc_x -= dx;
            acc_y -= dy;
            acc_w -= dw;
            push_report(buttons_now, dx, dy, dw, 1'b0);
        end
    endtask

    // pending motion goes out with the old buttons before the change
    task automatic change_buttons(logic [7:0] bits);
        logic [7:0] next;
        next = bits & cfg_button_mask;
        if (next != buttons_now) begin
            flush_motion();
            buttons_now = next;
            push_report(buttons_now, 0, 0, 0, 1'b1);
        end
    endtask

    task automatic predict_reports(t_command cmd, logic signed [15:0] mx, logic signed [15:0] my,
                                   logic signed [15:0] mw, logic [7:0] bits, logic prs);
        t_report r;
        item_reports.delete();
        case (cmd)
            CMD_MOVE: begin
                if (mx != 0 || my != 0) begin
                    acc_x = acc_sat(acc_x, int'(mx));
                    acc_y = acc_sat(acc_y, int'(my));
                    arm_timer();
                end
            end
            CMD_WHEEL: begin
                if (mw != 0) begin
                    acc_w = acc_sat(acc_w, int'(mw));
                    arm_timer();
                end
            end
            CMD_ONE_BTN: begin
                // zero or out-of-mask bits are ignored
                if (bits != 0 && (bits & ~cfg_button_mask) == 0) begin
                    change_buttons(prs ? (buttons_now | bits) : (buttons_now & ~bits));
                end
            end
            CMD_ALL_BTN: change_buttons(bits);
            CMD_RELEASE: begin
                flush_motion();
                if (buttons_now != 0) begin
                    buttons_now = '0;
                    push_report(8'd0, 0, 0, 0, 1'b1);
                end
            end
            CMD_RESET: begin
                timer_on    = 1'b0;
                timer_left  = 0;
                acc_x       = 0;
                acc_y       = 0;
                acc_w       = 0;
                buttons_now = '0;
            end
            CMD_FLUSH: flush_motion();
            CMD_TICK: begin
                if (timer_on) begin
                    if (timer_left > 0) timer_left--;
                    if (timer_left == 0) flush_motion();
                end
            end
            default: ;
        endcase
        if (item_reports.size() > 0) begin
            r = item_reports.pop_back();
            r.last = 1'b1;
            item_reports.push_back(r);
        end
        foreach (item_reports[k]) expected_reports.push_back(item_reports[k]);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle stretch length: mostly short, now and then long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offers one word, holds it until taken, then predicts its reports
    task automatic send_word(t_command cmd, logic signed [15:0] mx, logic signed [15:0] my,
                             logic signed [15:0] mw, logic [7:0] bits, logic prs);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 40) ? pick_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_move_x       <= mx;
        i_move_y       <= my;
        i_wheel_amount <= mw;
        i_button_bits  <= bits;
        i_pressed      <= prs;
        do @(posedge i_clk); while (o_in_stall);
        predict_reports(cmd, mx, my, mw, bits, prs);
        words_per_cmd[int'(cmd)]++;
    endtask

    // fields a command does not use carry random content
    task automatic send_cmd(t_command cmd);
        send_word(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_move(logic signed [15:0] mx, logic signed [15:0] my);
        send_word(CMD_MOVE, mx, my, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_wheel(logic signed [15:0] mw);
        send_word(CMD_WHEEL, 16'($urandom), 16'($urandom), mw, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_buttons(t_command cmd, logic [7:0] bits, logic prs);
        send_word(cmd, 16'($urandom), 16'($urandom), 16'($urandom), bits, prs);
    endtask

    // stop offering, let every owed report arrive, then give the block time to settle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    // write all four registers on consecutive edges while the block is idle
    task automatic set_registers(logic [15:0] ft, logic [7:0] mask, logic [6:0] maxd,
                                 logic signed [7:0] mind);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FLUSH_TICKS;
        i_cfg_data  <= ft;
        @(posedge i_clk);
        i_cfg_index <= REG_BUTTON_MASK;
        i_cfg_data  <= 16'(mask);
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_DELTA;
        i_cfg_data  <= 16'(maxd);
        @(posedge i_clk);
        i_cfg_index <= REG_MIN_DELTA;
        i_cfg_data  <= 16'(mind);
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        cfg_flush_ticks = ft;
        cfg_button_mask = mask;
        cfg_max_delta   = maxd;
        cfg_min_delta   = mind;
        settings_used++;
    endtask

    // mostly human-sized motion, some large, some across the full field
    function automatic logic signed [15:0] motion_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(0, 400) - 200);
        if (r < 88) return 16'($urandom_range(0, 4000) - 2000);
        return 16'($urandom);
    endfunction

    task automatic send_random_word();
        t_command           cmd;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mw;
        logic [7:0]         bits;
        logic               prs;
        int                 pick;
        int                 k;
        mx   = 16'($urandom);
        my   = 16'($urandom);
        mw   = 16'($urandom);
        bits = 8'($urandom);
        prs  = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            cmd = CMD_MOVE;
            mx  = motion_amount();
            my  = motion_amount();
            if ($urandom_range(0, 19) == 0) begin
                mx = '0;
                my = '0;
            end
        end else if (pick < 44) begin
            cmd = CMD_WHEEL;
            mw  = ($urandom_range(0, 19) == 0) ? 16'sd0 : motion_amount();
        end else if (pick < 70) begin
            cmd = CMD_TICK;
        end else if (pick < 80) begin
            cmd = CMD_ONE_BTN;
            // mostly a single legal button, otherwise raw bits
            if (cfg_button_mask != 0 && $urandom_range(0, 9) < 8) begin
                do k = $urandom_range(0, 7); while (!cfg_button_mask[k]);
                bits = 8'd1 << k;
            end
        end else if (pick < 87) begin
            cmd = CMD_ALL_BTN;
            if ($urandom_range(0, 3) != 0) bits = bits & cfg_button_mask;
        end else if (pick < 93) begin
            cmd = CMD_RELEASE;
        end else if (pick < 98) begin
            cmd = CMD_FLUSH;
        end else begin
            cmd = CMD_RESET;
        end
        send_word(cmd, mx, my, mw, bits, prs);
    endtask

    // ------------------------------------------------------------------
    // report checking and output stall
    // ------------------------------------------------------------------

    task automatic check_report();
        t_report want;
        if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("unexpected report: btn %h x %0d y %0d w %0d chg %0b last %0b",
                         o_report_buttons, o_report_x, o_report_y, o_report_wheel,
                         o_buttons_changed, o_last);
        end else begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (o_report_valid !== 1'b1 || o_report_buttons !== want.buttons
                    || o_report_x !== want.dx || o_report_y !== want.dy
                    || o_report_wheel !== want.dw || o_buttons_changed !== want.changed
                    || o_last !== want.last) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES) begin
                    $display("report %0d exp: vld 1 btn %h x %0d y %0d w %0d chg %0b last %0b",
                             reports_checked, want.buttons, want.dx, want.dy, want.dw,
                             want.changed, want.last);
                    $display("    got: vld %0b btn %h x %0d y %0d w %0d chg %0b last %0b",
                             o_report_valid, o_report_buttons, o_report_x, o_report_y,
                             o_report_wheel, o_buttons_changed, o_last);
                end
            end
        end
    endtask

    // checks each taken report word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_report();
        end
    end

    // drives the output stall, counting out a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served++;
            stall_left = LONG_HOLD;
        end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
            stall_left = pick_len();
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // timer start, no restart, zero motion, idle tick, saturation and empty flush
    task automatic test_motion_timer();
        send_cmd(CMD_TICK);
        send_move(16'sd0, 16'sd0);
        send_wheel(16'sd0);
        send_move(16'sd5, -16'sd3);
        send_cmd(CMD_TICK);
        send_wheel(-16'sd32768);
        send_move(16'sd32767, -16'sd32768);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_TICK);
        send_cmd(CMD_FLUSH);
    endtask

    // single and full button changes, ignored and unchanged cases, release and reset
    task automatic test_button_changes();
        send_buttons(CMD_ONE_BTN, 8'h01, 1'b1);
        send_buttons(CMD_ONE_BTN, 8'h01, 1'b1);
        send_buttons(CMD_ONE_BTN, 8'h00, 1'b1);
        send_buttons(CMD_ONE_BTN, 8'h80, 1'b1);
        send_move(16'sd200, -16'sd200);
        send_buttons(CMD_ALL_BTN, 8'hFF, 1'b0);
        send_buttons(CMD_ONE_BTN, 8'h02, 1'b0);
        send_move(16'sd1, 16'sd1);
        send_cmd(CMD_RELEASE);
        send_cmd(CMD_RELEASE);
        send_buttons(CMD_ALL_BTN, 8'h0C, 1'b0);
        send_move(16'sd100, 16'sd100);
        send_cmd(CMD_RESET);
        send_cmd(CMD_TICK);
    endtask

    // zero flush ticks and delta bounds below the legal range: longest flush
    task automatic test_delta_bounds();
        set_registers(16'd0, 8'd31, 7'd0, 8'sd0);
        send_move(16'sd32767, 16'sd32767);
        send_wheel(-16'sd32768);
        send_cmd(CMD_TICK);
    endtask

    task automatic random_phase(int count);
        repeat (count) send_random_word();
    endtask

    // every tick flushes, narrowest deltas, all eight buttons legal
    task automatic test_fast_timer();
        set_registers(16'd1, 8'hFF, 7'd16, -8'sd16);
        random_phase(80);
    endtask

    // timer never runs out, no legal buttons, widest deltas
    task automatic test_slow_timer();
        set_registers(16'hFFFF, 8'h00, 7'd127, -8'sd128);
        random_phase(60);
    endtask

    task automatic test_random_settings();
        logic signed [7:0] mind;
        repeat (3) begin
            mind = ($urandom_range(0, 9) < 7) ? 8'(-$urandom_range(16, 128)) : 8'($urandom);
            set_registers(16'($urandom_range(0, 12)), 8'($urandom), 7'($urandom), mind);
            random_phase(60);
        end
    endtask

    // reset register values, no idling on either side
    task automatic test_back_to_back();
        set_registers(16'd4, 8'd31, 7'd127, -8'sd127);
        calm = 1'b1;
        random_phase(60);
        calm = 1'b0;
        quiesce();
    endtask

    // output held off for a long stretch while big motion and flushes keep coming
    task automatic test_backpressure();
        int n;
        calm = 1'b1;
        hold_requests++;
        for (n = 0; n < 30; n++) begin
            if (n % 4 == 3) send_cmd(CMD_FLUSH);
            else send_move(16'($urandom), 16'($urandom));
        end
        calm = 1'b0;
        quiesce();
    endtask

    initial begin
        reset_predictor();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_motion_timer();
        test_button_changes();
        test_delta_bounds();
        test_fast_timer();
        test_slow_timer();
        test_random_settings();
        test_back_to_back();
        test_backpressure();
        quiesce();
        $display("covered %0d move, %0d wheel, %0d button, %0d tick, %0d flush, %0d reset words",
                 words_per_cmd[CMD_MOVE], words_per_cmd[CMD_WHEEL],
                 words_per_cmd[CMD_ONE_BTN] + words_per_cmd[CMD_ALL_BTN]
                     + words_per_cmd[CMD_RELEASE],
                 words_per_cmd[CMD_TICK], words_per_cmd[CMD_FLUSH], words_per_cmd[CMD_RESET]);
        $display("%0d reports compared under %0d register settings, %0d failures",
                 reports_checked, settings_used, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== mouse_report_coalescer.f =====
hdl/mrc_pkg.sv
hdl/mrc_ctrl.sv
hdl/mrc_datapath.sv
hdl/mouse_report_coalescer.sv
dv/mouse_report_coalescer_tb.sv
